// File: rtl/lpp_pkg.sv
// ----------------------------------------------------------------------------
// lpp_pkg
// Shared types and constants for the lidar point projector and colouriser.
// ----------------------------------------------------------------------------
package lpp_pkg;

  localparam int COORD_FRAC_BITS = 8;
  localparam int COORD_W         = 24;
  localparam int PIX_W           = 13;
  localparam int CH_W            = 8;
  localparam int CFG_IDX_W       = 4;
  localparam int CFG_DATA_W      = 64;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_A  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_B  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_A  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_B  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_A  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_B  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 4'd7;

  localparam logic [PIX_W-1:0] WIDTH_RST  = 13'd1242;
  localparam logic [PIX_W-1:0] HEIGHT_RST = 13'd375;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_pos;
    logic signed [COORD_W-1:0] y_pos;
    logic signed [COORD_W-1:0] z_pos;
  } in_t;

  typedef struct packed {
    logic             visible;
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
  } out_t;

endpackage

// File: rtl/lidar_point_projection_colorizer.sv
// ----------------------------------------------------------------------------
// lidar_point_projection_colorizer
// Projects lidar points through a 3x4 matrix and colours them by distance.
// ----------------------------------------------------------------------------
// pipeline: stage 1 products, stage 2 sums, divider set-up, then the 13-stage
// restoring divider with the 8-step ramp search alongside it, then the output register
// throughput: one point per cycle; a result stall holds the whole pipeline
// reset: synchronous active-low; matrix clears to zero, image size to 1242x375
module lidar_point_projection_colorizer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  lpp_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output lpp_pkg::out_t                      out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lpp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lpp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int F     = lpp_pkg::COORD_FRAC_BITS;
  localparam int PW    = 56;
  localparam int SW    = 58;
  localparam int QW    = lpp_pkg::PIX_W;
  localparam int DW    = SW + QW;
  localparam int NSTG  = QW;
  localparam int RHS_W = 60;
  localparam int LSH   = 2 * F - 2;
  localparam logic [47:0] H2 = 48'(625) << (2 * F);

  typedef enum logic [1:0] {RG_NEAR, RG_FAR, RG_BEYOND} region_t;

  typedef struct packed {
    logic             rej;
    region_t          region;
    logic [DW-1:0]    w;
    logic [DW-1:0]    ru;
    logic [DW-1:0]    rv;
    logic [QW-1:0]    qu;
    logic [QW-1:0]    qv;
    logic [7:0]       n;
    logic [RHS_W-1:0] rhs;
  } dstg_t;

  logic [63:0]          coef_r [0:5];
  logic [QW-1:0]        width_r;
  logic [QW-1:0]        height_r;

  logic                 en;
  logic                 s1_vld_r;
  logic signed [PW-1:0] s1_prod_r [0:2][0:3];
  logic [46:0]          s1_sq_r [0:2];
  logic                 s1_close_r;
  logic                 s2_vld_r;
  logic signed [SW-1:0] s2_sum_r [0:2];
  logic [47:0]          s2_s_r;
  logic                 s2_close_r;
  logic                 dv_r [0:NSTG];
  dstg_t                d_r [0:NSTG];
  dstg_t                d_nxt [0:NSTG];
  logic                 out_vld_r;
  lpp_pkg::out_t        out_data_r;
  lpp_pkg::out_t        out_nxt;

  logic signed [23:0]   crd [0:2];
  logic signed [PW-1:0] prod_nxt [0:2][0:3];
  logic [46:0]          sq_nxt [0:2];
  logic                 close_nxt;

  assign en        = !(out_vld_r && out_stall);
  assign in_stall  = out_vld_r && out_stall;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) coef_r[i] <= '0;
      width_r  <= lpp_pkg::WIDTH_RST;
      height_r <= lpp_pkg::HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lpp_pkg::REG_ROW0_A: coef_r[0] <= cfg_data;
        lpp_pkg::REG_ROW0_B: coef_r[1] <= cfg_data;
        lpp_pkg::REG_ROW1_A: coef_r[2] <= cfg_data;
        lpp_pkg::REG_ROW1_B: coef_r[3] <= cfg_data;
        lpp_pkg::REG_ROW2_A: coef_r[4] <= cfg_data;
        lpp_pkg::REG_ROW2_B: coef_r[5] <= cfg_data;
        lpp_pkg::REG_WIDTH:  width_r   <= cfg_data[QW-1:0];
        lpp_pkg::REG_HEIGHT: height_r  <= cfg_data[QW-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: matrix products, squares and the close-range test
  always_comb begin
    logic signed [31:0]   cf;
    logic signed [PW-1:0] cext;
    logic signed [27:0]   x10;
    crd[0] = in_data.x_pos;
    crd[1] = in_data.y_pos;
    crd[2] = in_data.z_pos;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        cf = coef_r[2 * r + c / 2][32 * (c % 2) +: 32];
        prod_nxt[r][c] = cf * crd[c];
      end
      // column 3 applies to the constant coordinate 1.0
      cf = coef_r[2 * r + 1][63:32];
      cext = {{(PW - 32){cf[31]}}, cf};
      prod_nxt[r][3] = cext <<< F;
    end
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = 47'(48'(crd[i] * crd[i]));
    end
    x10 = {{4{in_data.x_pos[23]}}, in_data.x_pos};
    x10 = x10 * 28'sd10;
    close_nxt = x10 < (28'sd1 <<< F);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod_r  <= prod_nxt;
      s1_sq_r    <= sq_nxt;
      s1_close_r <= close_nxt;
    end
  end

  // stage 2: row sums and squared distance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        s2_sum_r[r] <= SW'(s1_prod_r[r][0]) + SW'(s1_prod_r[r][1])
                     + SW'(s1_prod_r[r][2]) + SW'(s1_prod_r[r][3]);
      end
      s2_s_r     <= 48'(s1_sq_r[0]) + 48'(s1_sq_r[1]) + 48'(s1_sq_r[2]);
      s2_close_r <= s1_close_r;
    end
  end

  // stage 3: rejection tests and divider set-up; then divider and ramp steps
  always_comb begin
    logic [DW-1:0] wd;
    logic [DW-1:0] ud;
    logic [DW-1:0] vd;
    logic [DW-1:0] sh;
    logic [7:0]    cand;
    logic [9:0]    t;
    logic [19:0]   tsq;
    logic [24:0]   t25;
    logic [RHS_W-1:0] lhs;
    wd = DW'(unsigned'(s2_sum_r[2]));
    ud = DW'(unsigned'(s2_sum_r[0]));
    vd = DW'(unsigned'(s2_sum_r[1]));
    d_nxt[0].rej = s2_close_r || (s2_sum_r[2] <= 0) || s2_sum_r[0][SW-1]
                   || s2_sum_r[1][SW-1] || (ud >= (wd << QW)) || (vd >= (wd << QW));
    d_nxt[0].w  = wd;
    d_nxt[0].ru = ud;
    d_nxt[0].rv = vd;
    d_nxt[0].qu = '0;
    d_nxt[0].qv = '0;
    d_nxt[0].n  = '0;
    d_nxt[0].rhs = RHS_W'(s2_s_r) * RHS_W'(2601);
    if (s2_s_r < H2)             d_nxt[0].region = RG_NEAR;
    else if (s2_s_r < (H2 << 2)) d_nxt[0].region = RG_FAR;
    else                         d_nxt[0].region = RG_BEYOND;

    for (int j = 0; j < NSTG; j++) begin
      d_nxt[j + 1] = d_r[j];
      sh = d_r[j].w << (QW - 1 - j);
      if (d_r[j].ru >= sh) begin
        d_nxt[j + 1].ru = d_r[j].ru - sh;
        d_nxt[j + 1].qu[QW - 1 - j] = 1'b1;
      end
      if (d_r[j].rv >= sh) begin
        d_nxt[j + 1].rv = d_r[j].rv - sh;
        d_nxt[j + 1].qv[QW - 1 - j] = 1'b1;
      end
      // ramp: one bit of the largest step count per stage, for as many stages as the count has bits
      cand = '0;
      t    = '0;
      tsq  = '0;
      t25  = '0;
      lhs  = '0;
      if (j < 8) begin
        cand = d_r[j].n | (8'd1 << (7 - j));
        if (d_r[j].region == RG_NEAR) t = {1'b0, cand, 1'b0} - 10'd1;
        else                          t = 10'd509 + {1'b0, cand, 1'b0};
        tsq = t * t;
        t25 = 25'(tsq) * 25'd25;
        lhs = RHS_W'(t25) << LSH;
        if (lhs <= d_r[j].rhs) d_nxt[j + 1].n = cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= NSTG; j++) dv_r[j] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= s2_vld_r;
      for (int j = 0; j < NSTG; j++) dv_r[j + 1] <= dv_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j <= NSTG; j++) d_r[j] <= d_nxt[j];
    end
  end

  // output: bounds test, rounding and colour
  always_comb begin
    dstg_t      f;
    logic       rej;
    logic       rnd_u;
    logic       rnd_v;
    f     = d_r[NSTG];
    rej   = f.rej || (f.qu >= width_r) || (f.qv >= height_r);
    rnd_u = {f.ru, 1'b0} >= {1'b0, f.w};
    rnd_v = {f.rv, 1'b0} >= {1'b0, f.w};
    out_nxt = '0;
    if (!rej) begin
      out_nxt.visible   = 1'b1;
      out_nxt.pixel_col = f.qu + QW'(rnd_u);
      out_nxt.pixel_row = f.qv + QW'(rnd_v);
      case (f.region)
        RG_NEAR: begin
          out_nxt.green = f.n;
          out_nxt.red   = 8'd255 - f.n;
        end
        RG_FAR: begin
          out_nxt.blue  = f.n;
          out_nxt.green = 8'd255 - f.n;
        end
        default: begin
          out_nxt.blue = 8'd255;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

endmodule
